### rtl/core/cwp_pkg.sv
// Package for the command word packer: constants, codes and shared structures.
package cwp_pkg;

  localparam int MAX_ARGS  = 8;
  localparam int WORD_BITS = 32;
  localparam int MAX_BYTES = WORD_BITS / 8;

  localparam int ARG_BITS  = 32;
  localparam int CFG_BITS  = 40;
  localparam int IDX_BITS  = 3;

  // Register indexes on the configuration port.
  localparam logic [IDX_BITS-1:0] REG_ARG_COUNT     = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ARG_WIDTHS    = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_ARG_ENCODINGS = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_ADDRESS_BYTE  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_COMMAND_BYTES = 3'd4;

  // Field encodings.
  localparam logic [1:0] ENC_UNSIGNED = 2'd0;
  localparam logic [1:0] ENC_TWOS     = 2'd1;
  localparam logic [1:0] ENC_OFFSET   = 2'd2;
  localparam logic [1:0] ENC_SIGN_MAG = 2'd3;

  // Register values after reset.
  localparam logic [3:0]  RST_ARG_COUNT     = 4'd1;
  localparam logic [2:0]  RST_COMMAND_BYTES = 3'd4;

  typedef struct packed {
    logic [3:0]  arg_count;
    logic [39:0] arg_widths;
    logic [15:0] arg_encodings;
    logic [7:0]  address_byte;
    logic [2:0]  command_bytes;
  } cwp_cfg_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] word;
    logic        length_error;
  } cwp_res_t;

endpackage

### rtl/core/cwp_cfg_regs.sv
// Configuration register file of the command word packer.
module cwp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [cwp_pkg::IDX_BITS-1:0]  wr_index,
  input  logic [cwp_pkg::CFG_BITS-1:0]  wr_data,
  output cwp_pkg::cwp_cfg_t             cfg
);

  cwp_pkg::cwp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arg_count     <= cwp_pkg::RST_ARG_COUNT;
      cfg_r.arg_widths    <= '0;
      cfg_r.arg_encodings <= '0;
      cfg_r.address_byte  <= '0;
      cfg_r.command_bytes <= cwp_pkg::RST_COMMAND_BYTES;
    end else if (wr_en) begin
      unique case (wr_index)
        cwp_pkg::REG_ARG_COUNT:     cfg_r.arg_count     <= wr_data[3:0];
        cwp_pkg::REG_ARG_WIDTHS:    cfg_r.arg_widths    <= wr_data[39:0];
        cwp_pkg::REG_ARG_ENCODINGS: cfg_r.arg_encodings <= wr_data[15:0];
        cwp_pkg::REG_ADDRESS_BYTE:  cfg_r.address_byte  <= wr_data[7:0];
        cwp_pkg::REG_COMMAND_BYTES: cfg_r.command_bytes <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/cwp_field_enc.sv
// Saturates one signed argument to its field width and encodes it.
module cwp_field_enc (
  input  logic signed [31:0] arg_value,
  input  logic [5:0]         width,
  input  logic [1:0]         encoding,
  output logic [31:0]        field
);

  logic signed [33:0] v;
  logic signed [33:0] half;
  logic signed [33:0] full;
  logic signed [33:0] lo;
  logic signed [33:0] hi;
  logic signed [33:0] clamped;
  logic signed [33:0] coded;
  logic [33:0]        mask;

  always_comb begin
    v    = 34'(arg_value);
    half = 34'(1) << (width - 6'd1);
    full = 34'(1) << width;
    mask = 34'(full - 34'sd1);

    case (encoding)
      cwp_pkg::ENC_UNSIGNED: begin
        lo = 34'sd0;
        hi = full - 34'sd1;
      end
      cwp_pkg::ENC_SIGN_MAG: begin
        lo = 34'sd1 - half;
        hi = half - 34'sd1;
      end
      default: begin
        lo = -half;
        hi = half - 34'sd1;
      end
    endcase

    if (v < lo) begin
      clamped = lo;
    end else if (v > hi) begin
      clamped = hi;
    end else begin
      clamped = v;
    end

    case (encoding)
      cwp_pkg::ENC_OFFSET:   coded = clamped + half;
      cwp_pkg::ENC_SIGN_MAG: coded = (clamped < 34'sd0) ? ((-clamped) | half) : clamped;
      default:               coded = clamped;
    endcase

    field = coded[31:0] & mask[31:0];
  end

endmodule

### rtl/core/cwp_accum.sv
// Running field word, field count and bit count, and command word assembly.
module cwp_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic signed [31:0]  arg_value,
  input  cwp_pkg::cwp_cfg_t   cfg,
  output cwp_pkg::cwp_res_t   res
);

  logic [31:0] packed_r;
  logic [2:0]  idx_r;
  logic [7:0]  used_r;

  logic [4:0]  wm1;
  logic [5:0]  w;
  logic [1:0]  enc;
  logic [31:0] field;
  logic [63:0] shifted;
  logic [31:0] packed_nxt;
  logic [8:0]  used_sum;
  logic [7:0]  used_nxt;
  logic [3:0]  count_c;
  logic        done;
  logic [2:0]  bytes_c;
  logic [5:0]  area;
  logic        err;
  logic [5:0]  gap;
  logic [31:0] word;

  assign wm1 = cfg.arg_widths[6'(idx_r) * 6'd5 +: 5];
  assign w   = {1'b0, wm1} + 6'd1;
  assign enc = cfg.arg_encodings[{idx_r, 1'b0} +: 2];

  cwp_field_enc u_enc (
    .arg_value (arg_value),
    .width     (w),
    .encoding  (enc),
    .field     (field)
  );

  always_comb begin
    shifted    = {32'b0, packed_r} << w;
    packed_nxt = shifted[31:0] | field;
    used_sum   = {1'b0, used_r} + {3'b0, w};
    used_nxt   = used_sum[8] ? 8'hFF : used_sum[7:0];

    if (cfg.arg_count == 4'd0) begin
      count_c = 4'd1;
    end else if (cfg.arg_count > 4'(cwp_pkg::MAX_ARGS)) begin
      count_c = 4'(cwp_pkg::MAX_ARGS);
    end else begin
      count_c = cfg.arg_count;
    end
    done = ({1'b0, idx_r} + 4'd1) >= count_c;

    if (cfg.command_bytes < 3'd2) begin
      bytes_c = 3'd2;
    end else if (cfg.command_bytes > 3'(cwp_pkg::MAX_BYTES)) begin
      bytes_c = 3'(cwp_pkg::MAX_BYTES);
    end else begin
      bytes_c = cfg.command_bytes;
    end
    area = {bytes_c - 3'd1, 3'b000};

    err  = used_nxt > {2'b0, area};
    gap  = area - used_nxt[5:0];
    word = (packed_nxt << gap) | (32'(cfg.address_byte) << area);

    res.fire         = step && done;
    res.length_error = err;
    res.word         = err ? 32'd0 : word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packed_r <= '0;
      idx_r    <= '0;
      used_r   <= '0;
    end else if (step) begin
      if (done) begin
        packed_r <= '0;
        idx_r    <= '0;
        used_r   <= '0;
      end else begin
        packed_r <= packed_nxt;
        idx_r    <= idx_r + 3'd1;
        used_r   <= used_nxt;
      end
    end
  end

endmodule

### rtl/core/command_word_packer_unit.sv
// Top level of the command word packer: input register, packing stage, result register.
// Path: the beat carrying a command's last argument is held in the input register and,
// once it is packed, the command word is loaded into the result register.
// Throughput: one argument beat per cycle, with the encode and shift done combinationally;
// the input only stalls while a finished command waits in the result register.
// Reset (rst_n low, synchronous) empties both registers, clears the running word
// and restores the configuration registers to their reset values.
module command_word_packer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // Argument stream. in_tdata: [31:0] arg_value.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,
  // Command stream. out_tdata: [31:0] command_word. out_tuser: [0] length_error.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,
  output logic                         out_tuser,
  // Configuration writes.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cwp_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [cwp_pkg::CFG_BITS-1:0] cfg_data
);

  cwp_pkg::cwp_cfg_t cfg;
  cwp_pkg::cwp_res_t res;

  logic        in_valid_r;
  logic [31:0] arg_r;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic        out_err_r;
  logic        proc;

  // Configuration is always taken at once; the user must write it only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  cwp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held argument is packed whenever the result register can take a
  // command word, i.e. it is empty or its word leaves in this cycle. Beats that
  // do not complete a command wait on the same condition, so a single term
  // controls the whole pipeline.
  assign proc      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      arg_r <= in_tdata;
    end
  end

  cwp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc),
    .arg_value (signed'(arg_r)),
    .cfg       (cfg),
    .res       (res)
  );

  // Result register: a finished command waits here, and no further arguments
  // are packed until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      out_word_r <= res.word;
      out_err_r  <= res.length_error;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_err_r;

  // A command with a length error always carries an all-zero word.
  a_err_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("length error beat with non-zero command word");

  // A completed command always shows up on the result side in the next cycle.
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    res.fire |=> out_tvalid)
    else $error("completed command did not reach the result register");

  // The input side is only held off while an argument waits to be packed.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a blocked argument");

endmodule
